// File: hw/rtl/keypad_debounce_longpress_repeat_macros.svh
// Assertion macros shared by the keypad scanner RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef KEYPAD_DEBOUNCE_LONGPRESS_REPEAT_MACROS_SVH
`define KEYPAD_DEBOUNCE_LONGPRESS_REPEAT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KDLR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KDLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/kdlr_pkg.sv
// Package for the keypad scanner: event codes, register indexes and the
// configuration bundle handed to the per-button lanes. No dependencies.
package kdlr_pkg;

    localparam int TIME_W     = 32;
    localparam int THR_W      = 8;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [THR_W-1:0]      THR_RESET         = 8'd5;
    localparam logic [MS_W-1:0]       LONG_PRESS_RESET  = 16'd1000;
    localparam logic [MS_W-1:0]       REPEAT_DELAY_RESET = 16'd500;
    localparam logic [MS_W-1:0]       REPEAT_RATE_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] REPEAT_MASK_RESET = 16'd6;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2,
        EV_REPEAT  = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_THRESHOLD = 3'd0,
        REG_HOLD_MS            = 3'd1,
        REG_FIRST_GAP_MS       = 3'd2,
        REG_STEADY_GAP_MS      = 3'd3,
        REG_REPEAT_ENABLE_MASK = 3'd4
    } cfg_index_t;

    // Timing settings shared by all lanes.
    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [MS_W-1:0]  hold_ms;
        logic [MS_W-1:0]  first_gap_ms;
        logic [MS_W-1:0]  steady_gap_ms;
    } kdlr_cfg_t;

    // Event produced by one lane for the scan under evaluation.
    typedef struct packed {
        logic        valid;
        event_kind_t kind;
    } lane_evt_t;

endpackage

// File: hw/rtl/kdlr_intf.sv
// Handshake interfaces of the keypad scanner: scan input, event output and
// register write channel. Depends on kdlr_pkg.
interface kdlr_scan_if #(parameter int NUM_BUTTONS = 6);
    logic                     valid;
    logic                     ready;
    logic [NUM_BUTTONS-1:0]   pressed_mask;
    logic [kdlr_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output pressed_mask, output now_ms, input ready);
    modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface

interface kdlr_event_if #(parameter int NUM_BUTTONS = 6);
    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic                        valid;
    logic                        ready;
    logic [IDX_W-1:0]            button_index;
    kdlr_pkg::event_kind_t       event_kind;
    logic [kdlr_pkg::TIME_W-1:0] event_time_ms;
    logic                        last_of_scan;

    modport source (output valid, output button_index, output event_kind,
                    output event_time_ms, output last_of_scan, input ready);
    modport sink   (input valid, input button_index, input event_kind,
                    input event_time_ms, input last_of_scan, output ready);
endinterface

interface kdlr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kdlr_pkg::CFG_IDX_W-1:0]  index;
    logic [kdlr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/kdlr_lane.sv
// One button lane: debounce counter, held/long-press state and event decision.
// Depends on kdlr_pkg.
module kdlr_lane #(
    parameter int COUNT_MAX = 255
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kdlr_pkg::kdlr_cfg_t         cfg,
    input  logic                        rep_en,
    input  logic                        sample,
    input  logic [kdlr_pkg::TIME_W-1:0] now_ms,
    input  logic                        update,
    output kdlr_pkg::lane_evt_t         evt
);
    import kdlr_pkg::*;

    localparam int CNT_W = $clog2(COUNT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              held_reg, held_next;
    logic              long_fired_reg, long_fired_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] last_rep_reg, last_rep_next;

    logic              level;
    logic [TIME_W-1:0] held_time;
    logic [TIME_W-1:0] since_rep;
    logic [MS_W:0]     hold_limit;
    logic [MS_W-1:0]   interval;

    // Saturating up/down debounce counter and the debounced level.
    always_comb
    begin
        if (sample)
        begin
            cnt_next = (cnt_reg == CNT_TOP) ? cnt_reg : cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = (cnt_reg == '0) ? cnt_reg : cnt_reg - CNT_W'(1);
        end
        level = 9'(cnt_next) > 9'(cfg.threshold);
    end

    // Elapsed times wrap modulo 2^32; the repeat interval switches to the steady
    // gap once the hold has run past the long press plus the first delay.
    always_comb
    begin
        held_time  = now_ms - start_reg;
        since_rep  = now_ms - last_rep_reg;
        hold_limit = {1'b0, cfg.hold_ms} + {1'b0, cfg.first_gap_ms};
        interval   = (held_time > TIME_W'(hold_limit)) ? cfg.steady_gap_ms
                                                        : cfg.first_gap_ms;
    end

    // Event decision, at most one event per scan.
    always_comb
    begin
        held_next       = held_reg;
        long_fired_next = long_fired_reg;
        start_next      = start_reg;
        last_rep_next   = last_rep_reg;
        evt.valid       = 1'b0;
        evt.kind        = EV_PRESS;
        if (level && !held_reg)
        begin
            held_next       = 1'b1;
            start_next      = now_ms;
            last_rep_next   = now_ms;
            long_fired_next = 1'b0;
            evt.valid       = 1'b1;
            evt.kind        = EV_PRESS;
        end
        else if (!level && held_reg)
        begin
            held_next = 1'b0;
            evt.valid = 1'b1;
            evt.kind  = EV_RELEASE;
        end
        else if (held_reg && !long_fired_reg)
        begin
            if (held_time >= TIME_W'(cfg.hold_ms))
            begin
                long_fired_next = 1'b1;
                evt.valid       = 1'b1;
                evt.kind        = EV_LONG;
                if (rep_en)
                begin
                    last_rep_next = now_ms;
                end
            end
        end
        else if (held_reg && long_fired_reg && rep_en)
        begin
            if (since_rep >= TIME_W'(interval))
            begin
                last_rep_next = now_ms;
                evt.valid     = 1'b1;
                evt.kind      = EV_REPEAT;
            end
        end
    end

    // Lane state advances when the scan moves into the event buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            held_reg       <= 1'b0;
            long_fired_reg <= 1'b0;
            start_reg      <= '0;
            last_rep_reg   <= '0;
        end
        else if (update)
        begin
            cnt_reg        <= cnt_next;
            held_reg       <= held_next;
            long_fired_reg <= long_fired_next;
            start_reg      <= start_next;
            last_rep_reg   <= last_rep_next;
        end
    end

endmodule

// File: hw/rtl/keypad_debounce_longpress_repeat.sv
// Keypad scanner with debounce, long press and auto-repeat. A scan transaction
// is registered on acceptance; all button lanes evaluate it in parallel and its
// events (zero to NUM_BUTTONS) drop into an event buffer once it is free, from
// which they leave in button order through the output register, one event
// transaction per cycle as evt.ready allows, the final one flagged last_of_scan.
// An event passes the scan, buffer and output registers. A new scan is taken
// every cycle while scans are quiet or give one event and the output is not
// held; a scan with more events holds the next scan until its last event
// leaves. Register writes take effect at once and are always accepted.
// Depends on kdlr_pkg, the kdlr interfaces, kdlr_lane and the macro header.
`include "keypad_debounce_longpress_repeat_macros.svh"

module keypad_debounce_longpress_repeat #(
    parameter int NUM_BUTTONS = 6,
    parameter int COUNT_MAX   = 255
) (
    input  logic clk,
    input  logic rst_n,
    kdlr_scan_if.sink    scan,
    kdlr_event_if.source evt,
    kdlr_cfg_if.sink     cfg
);
    import kdlr_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    // Configuration registers.
    logic [THR_W-1:0]       thr_reg;
    logic [MS_W-1:0]        long_press_reg;
    logic [MS_W-1:0]        repeat_delay_reg;
    logic [MS_W-1:0]        repeat_rate_reg;
    logic [NUM_BUTTONS-1:0] rep_mask_reg;
    kdlr_cfg_t              cfg_bundle;

    // Scan register, event buffer and output register.
    logic                   s1_valid_reg;
    logic [NUM_BUTTONS-1:0] s1_mask_reg;
    logic [TIME_W-1:0]      s1_now_reg;
    logic [NUM_BUTTONS-1:0] pend_reg, pend_next;
    event_kind_t            kind_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      buf_time_reg;
    logic                   out_valid_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    event_kind_t            out_kind_reg;
    logic [TIME_W-1:0]      out_time_reg;
    logic                   out_last_reg;

    lane_evt_t              lane_evt [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] lane_valid;
    logic [NUM_BUTTONS-1:0] pick_oh;
    logic [NUM_BUTTONS-1:0] rest;
    logic [IDX_W-1:0]       pick_idx;
    event_kind_t            pick_kind;
    logic                   pop;
    logic                   last_pop;
    logic                   buf_free;
    logic                   xfer;
    logic                   scan_accept;

    // Register writes; indexes past the list are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg          <= THR_RESET;
            long_press_reg   <= LONG_PRESS_RESET;
            repeat_delay_reg <= REPEAT_DELAY_RESET;
            repeat_rate_reg  <= REPEAT_RATE_RESET;
            rep_mask_reg     <= NUM_BUTTONS'(REPEAT_MASK_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_DEBOUNCE_THRESHOLD: thr_reg          <= cfg.data[THR_W-1:0];
                REG_HOLD_MS:            long_press_reg   <= cfg.data[MS_W-1:0];
                REG_FIRST_GAP_MS:       repeat_delay_reg <= cfg.data[MS_W-1:0];
                REG_STEADY_GAP_MS:      repeat_rate_reg  <= cfg.data[MS_W-1:0];
                REG_REPEAT_ENABLE_MASK: rep_mask_reg     <= cfg.data[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_bundle.threshold     = thr_reg;
    assign cfg_bundle.hold_ms       = long_press_reg;
    assign cfg_bundle.first_gap_ms  = repeat_delay_reg;
    assign cfg_bundle.steady_gap_ms = repeat_rate_reg;

    // Button lanes evaluate the registered scan in parallel.
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        kdlr_lane #(
            .COUNT_MAX (COUNT_MAX)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cfg    (cfg_bundle),
            .rep_en (rep_mask_reg[i]),
            .sample (s1_mask_reg[i]),
            .now_ms (s1_now_reg),
            .update (xfer),
            .evt    (lane_evt[i])
        );
        assign lane_valid[i] = lane_evt[i].valid;
    end

    // Pick the lowest pending button for the output register.
    always_comb
    begin
        pick_oh   = pend_reg & (~pend_reg + NUM_BUTTONS'(1));
        rest      = pend_reg & ~pick_oh;
        pick_idx  = '0;
        pick_kind = EV_PRESS;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (pick_oh[i])
            begin
                pick_idx  = IDX_W'(i);
                pick_kind = kind_reg[i];
            end
        end
    end

    // Flow control: the buffer takes a new scan once its last event leaves.
    assign pop         = (pend_reg != '0) && (!out_valid_reg || evt.ready);
    assign last_pop    = pop && (rest == '0);
    assign buf_free    = (pend_reg == '0) || last_pop;
    assign xfer        = s1_valid_reg && buf_free;
    assign scan.ready  = !s1_valid_reg || buf_free;
    assign scan_accept = scan.valid && scan.ready;

    always_comb
    begin
        if (xfer)
        begin
            pend_next = lane_valid;
        end
        else if (pop)
        begin
            pend_next = rest;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (xfer)
            begin
                s1_valid_reg <= 1'b0;
            end
            pend_reg <= pend_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (scan_accept)
        begin
            s1_mask_reg <= scan.pressed_mask;
            s1_now_reg  <= scan.now_ms;
        end
        if (xfer)
        begin
            buf_time_reg <= s1_now_reg;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                kind_reg[i] <= lane_evt[i].kind;
            end
        end
        if (pop)
        begin
            out_idx_reg  <= pick_idx;
            out_kind_reg <= pick_kind;
            out_time_reg <= buf_time_reg;
            out_last_reg <= (rest == '0);
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.button_index  = out_idx_reg;
    assign evt.event_kind    = out_kind_reg;
    assign evt.event_time_ms = out_time_reg;
    assign evt.last_of_scan  = out_last_reg;

    // A scan enters the buffer only as the previous scan's last event leaves.
    `KDLR_ASSERT_IMPL(a_xfer_drained, xfer && (pend_reg != '0), last_pop, "scan overwrote events")
    // Events of a scan not yet finished are still waiting in the buffer.
    `KDLR_ASSERT_IMPL(a_rest_pending, out_valid_reg && !out_last_reg, pend_reg != '0, "events lost")
    // A popped event always lands in the output register.
    `KDLR_ASSERT_NEXT(a_pop_lands, pop, out_valid_reg, "popped event missing at output")
    // The reported button is always a real button.
    `KDLR_ASSERT_IMPL(a_idx_range, out_valid_reg, out_idx_reg <= LAST_IDX, "index out of range")

endmodule
